// ===== sv/sphere_dir_to_cube_face_uv_top_assert.svh =====
// Assertion macros used by the cube face selection top level.
`ifndef SPHERE_DIR_TO_CUBE_FACE_UV_TOP_ASSERT_SVH
`define SPHERE_DIR_TO_CUBE_FACE_UV_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SDCF_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Implication with a fixed delay in cycles, disabled during reset.
`define SDCF_ASSERT_DELAY(lbl, ck, rs, ante, dly, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== sv/sdcf_pkg.sv =====
// Shared types and constants for the cube face selection pipeline.
`default_nettype none
package sdcf_pkg;

  localparam int unsigned COMP_BITS_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF = 15;

  // Cube face codes
  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  // Per-transaction control carried alongside the divider data
  typedef struct packed {
    face_t face;
    logic  zero;   // major magnitude is zero: both coordinates are zero
    logic  u_neg;
    logic  v_neg;
  } sdcf_ctl_t;

endpackage
`default_nettype wire

// ===== sv/sdcf_select.sv =====
// Two-stage front end: component magnitudes, then face and minor selection.
`default_nettype none
module sdcf_select #(
  parameter int unsigned COMP_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic [COMP_BITS-1:0]   dir_x,
  input  wire logic [COMP_BITS-1:0]   dir_y,
  input  wire logic [COMP_BITS-1:0]   dir_z,
  output logic                        out_valid,
  output sdcf_pkg::sdcf_ctl_t         ctl,
  output logic [COMP_BITS-1:0]        major,
  output logic [COMP_BITS-1:0]        minor_u,
  output logic [COMP_BITS-1:0]        minor_v
);
  import sdcf_pkg::*;

  localparam logic [COMP_BITS-1:0] ONE_C = {{(COMP_BITS-1){1'b0}}, 1'b1};
  localparam logic [COMP_BITS-1:0] ZERO_C = '0;

  logic                 a_valid;
  logic                 a_neg_x, a_neg_y, a_neg_z;
  logic [COMP_BITS-1:0] a_mag_x, a_mag_y, a_mag_z;

  sdcf_ctl_t            ctl_next;
  logic [COMP_BITS-1:0] major_next, minor_u_next, minor_v_next;

  // Stage A valid
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  // Stage A: sign and magnitude (most negative value maps to 2^(COMP_BITS-1))
  always_ff @(posedge clk) begin
    a_neg_x <= dir_x[COMP_BITS-1];
    a_neg_y <= dir_y[COMP_BITS-1];
    a_neg_z <= dir_z[COMP_BITS-1];
    a_mag_x <= dir_x[COMP_BITS-1] ? (~dir_x + ONE_C) : dir_x;
    a_mag_y <= dir_y[COMP_BITS-1] ? (~dir_y + ONE_C) : dir_y;
    a_mag_z <= dir_z[COMP_BITS-1] ? (~dir_z + ONE_C) : dir_z;
  end

  // Face choice: X wins ties over Y and Z, Y over Z
  always_comb begin
    ctl_next = '{face: FACE_POS_X, zero: 1'b0, u_neg: 1'b0, v_neg: 1'b0};
    major_next   = a_mag_x;
    minor_u_next = a_mag_z;
    minor_v_next = a_mag_y;
    priority if (a_mag_x >= a_mag_y && a_mag_x >= a_mag_z) begin
      major_next     = a_mag_x;
      ctl_next.face  = a_neg_x ? FACE_NEG_X : FACE_POS_X;
      minor_u_next   = a_mag_z;
      minor_v_next   = a_mag_y;
      ctl_next.v_neg = a_neg_y;
      ctl_next.u_neg = a_neg_x ? a_neg_z : ~a_neg_z;
    end else if (a_mag_y >= a_mag_z) begin
      major_next     = a_mag_y;
      ctl_next.face  = a_neg_y ? FACE_NEG_Y : FACE_POS_Y;
      minor_u_next   = a_mag_x;
      ctl_next.u_neg = a_neg_x;
      minor_v_next   = a_mag_z;
      ctl_next.v_neg = a_neg_y ? ~a_neg_z : a_neg_z;
    end else begin
      major_next     = a_mag_z;
      ctl_next.face  = a_neg_z ? FACE_NEG_Z : FACE_POS_Z;
      minor_u_next   = a_mag_x;
      ctl_next.u_neg = a_neg_z ? ~a_neg_x : a_neg_x;
      minor_v_next   = a_mag_y;
      ctl_next.v_neg = a_neg_y;
    end
    ctl_next.zero = (major_next == ZERO_C);
  end

  // Stage B valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
  end

  // Stage B payload
  always_ff @(posedge clk) begin
    ctl     <= ctl_next;
    major   <= major_next;
    minor_u <= minor_u_next;
    minor_v <= minor_v_next;
  end

endmodule
`default_nettype wire

// ===== sv/sdcf_div_stage.sv =====
// One restoring-division stage: one quotient bit for each of the two lanes.
`default_nettype none
module sdcf_div_stage #(
  parameter int unsigned COMP_BITS = 24,
  parameter int unsigned FRAC_BITS = 15,
  parameter bit          SHIFT     = 1'b1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire sdcf_pkg::sdcf_ctl_t    in_ctl,
  input  wire logic [COMP_BITS-1:0]   in_major,
  input  wire logic [COMP_BITS-1:0]   in_rem_u,
  input  wire logic [COMP_BITS-1:0]   in_rem_v,
  input  wire logic [FRAC_BITS:0]     in_quo_u,
  input  wire logic [FRAC_BITS:0]     in_quo_v,
  output logic                        out_valid,
  output sdcf_pkg::sdcf_ctl_t         out_ctl,
  output logic [COMP_BITS-1:0]        out_major,
  output logic [COMP_BITS-1:0]        out_rem_u,
  output logic [COMP_BITS-1:0]        out_rem_v,
  output logic [FRAC_BITS:0]          out_quo_u,
  output logic [FRAC_BITS:0]          out_quo_v
);
  import sdcf_pkg::*;

  logic [COMP_BITS:0] div_ext;
  logic [COMP_BITS:0] trial_u, trial_v;
  logic [COMP_BITS:0] diff_u, diff_v;
  logic               ge_u, ge_v;

  // Partial remainder stays below the divisor, so the doubled value fits
  always_comb begin
    div_ext = {1'b0, in_major};
    if (SHIFT) begin
      trial_u = {in_rem_u, 1'b0};
      trial_v = {in_rem_v, 1'b0};
    end else begin
      trial_u = {1'b0, in_rem_u};
      trial_v = {1'b0, in_rem_v};
    end
    ge_u   = (trial_u >= div_ext);
    ge_v   = (trial_v >= div_ext);
    diff_u = ge_u ? (trial_u - div_ext) : trial_u;
    diff_v = ge_v ? (trial_v - div_ext) : trial_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ctl   <= in_ctl;
    out_major <= in_major;
    out_rem_u <= diff_u[COMP_BITS-1:0];
    out_rem_v <= diff_v[COMP_BITS-1:0];
    out_quo_u <= {in_quo_u[FRAC_BITS-1:0], ge_u};
    out_quo_v <= {in_quo_v[FRAC_BITS-1:0], ge_v};
  end

endmodule
`default_nettype wire

// ===== sv/sphere_dir_to_cube_face_uv_top.sv =====
// Top level of the cube-map face selection and face coordinate pipeline.
// Usage:
//   A direction (dir_x, dir_y, dir_z, two's complement, COMP_BITS each) is
//   taken as a transaction at a rising edge where start is high and busy is
//   low. busy is high only while rst is asserted; otherwise a transaction
//   may be issued on every cycle.
//   The result (face, u_coord, v_coord in Q1.FRAC_BITS) appears with done
//   high for exactly one cycle. Results come out in issue order.
//   Throughput is one transaction per cycle. The pipeline holds the two
//   front-end stages (magnitudes, then face choice), one restoring-division
//   stage per quotient bit (FRAC_BITS+1 of them, both coordinates in
//   parallel) and the output register.
//   The receiver cannot hold results off; done is a strobe only.
//   A synchronous reset drops every transaction in flight and clears done.
`default_nettype none
module sphere_dir_to_cube_face_uv_top #(
  parameter int unsigned COMP_BITS = sdcf_pkg::COMP_BITS_DEF,
  parameter int unsigned FRAC_BITS = sdcf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COMP_BITS-1:0]  dir_x,
  input  wire logic [COMP_BITS-1:0]  dir_y,
  input  wire logic [COMP_BITS-1:0]  dir_z,
  output logic                       done,
  output logic [2:0]                 face,
  output logic [FRAC_BITS+1:0]       u_coord,
  output logic [FRAC_BITS+1:0]       v_coord
);
  import sdcf_pkg::*;

  `include "sphere_dir_to_cube_face_uv_top_assert.svh"

  localparam int unsigned NSTAGE  = FRAC_BITS + 1;
  // Edges from the accepting edge to the edge that takes the result
  localparam int unsigned LATENCY = FRAC_BITS + 4;
  localparam logic [FRAC_BITS+1:0] CRD_ONE = {{(FRAC_BITS+1){1'b0}}, 1'b1};
  localparam logic [FRAC_BITS+1:0] CRD_UNIT = CRD_ONE << FRAC_BITS;

  logic                 accept;
  logic                 valid_s   [0:NSTAGE];
  sdcf_ctl_t            ctl_s     [0:NSTAGE];
  logic [COMP_BITS-1:0] major_s   [0:NSTAGE];
  logic [COMP_BITS-1:0] rem_u_s   [0:NSTAGE];
  logic [COMP_BITS-1:0] rem_v_s   [0:NSTAGE];
  logic [FRAC_BITS:0]   quo_u_s   [0:NSTAGE];
  logic [FRAC_BITS:0]   quo_v_s   [0:NSTAGE];

  logic [FRAC_BITS+1:0] u_next, v_next;

  assign busy   = rst;
  assign accept = start & ~busy;

  // Front end: magnitudes and face choice
  sdcf_select #(
    .COMP_BITS(COMP_BITS)
  ) u_select (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .out_valid(valid_s[0]),
    .ctl      (ctl_s[0]),
    .major    (major_s[0]),
    .minor_u  (rem_u_s[0]),
    .minor_v  (rem_v_s[0])
  );

  assign quo_u_s[0] = '0;
  assign quo_v_s[0] = '0;

  // Division chain: weight 2^FRAC_BITS first, so no doubling in stage 0
  for (genvar k = 0; k < NSTAGE; k++) begin : g_div
    sdcf_div_stage #(
      .COMP_BITS(COMP_BITS),
      .FRAC_BITS(FRAC_BITS),
      .SHIFT    (k != 0)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid_s[k]),
      .in_ctl   (ctl_s[k]),
      .in_major (major_s[k]),
      .in_rem_u (rem_u_s[k]),
      .in_rem_v (rem_v_s[k]),
      .in_quo_u (quo_u_s[k]),
      .in_quo_v (quo_v_s[k]),
      .out_valid(valid_s[k+1]),
      .out_ctl  (ctl_s[k+1]),
      .out_major(major_s[k+1]),
      .out_rem_u(rem_u_s[k+1]),
      .out_rem_v(rem_v_s[k+1]),
      .out_quo_u(quo_u_s[k+1]),
      .out_quo_v(quo_v_s[k+1])
    );
  end

  // Apply sign; zero major gives zero coordinates
  always_comb begin
    u_next = {1'b0, quo_u_s[NSTAGE]};
    v_next = {1'b0, quo_v_s[NSTAGE]};
    if (ctl_s[NSTAGE].zero) begin
      u_next = '0;
      v_next = '0;
    end else begin
      if (ctl_s[NSTAGE].u_neg) begin
        u_next = ~u_next + CRD_ONE;
      end
      if (ctl_s[NSTAGE].v_neg) begin
        v_next = ~v_next + CRD_ONE;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_s[NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    face    <= ctl_s[NSTAGE].face;
    u_coord <= u_next;
    v_coord <= v_next;
  end

  // Checks
  `SDCF_ASSERT_DELAY(a_done_follows_accept, clk, rst, accept, LATENCY, done,
    "accepted transaction did not produce a result")
  `SDCF_ASSERT_NOW(a_done_has_accept, clk, rst, done, $past(accept, LATENCY),
    "result strobe without a matching transaction")
  `SDCF_ASSERT_NOW(a_coord_range, clk, rst, done,
    ($signed(u_coord) <= $signed(CRD_UNIT)) && ($signed(u_coord) >= -$signed(CRD_UNIT))
    && ($signed(v_coord) <= $signed(CRD_UNIT)) && ($signed(v_coord) >= -$signed(CRD_UNIT)),
    "face coordinate outside [-1, 1]")

endmodule
`default_nettype wire

// ===== bench/tb_sphere_dir_to_cube_face_uv_top.sv =====
// Testbench for the cube-map face selection and face coordinate pipeline.
`timescale 1ns / 1ps

module tb_sphere_dir_to_cube_face_uv_top;
  import sdcf_pkg::*;

  localparam int unsigned COMP_W  = COMP_BITS_DEF;
  localparam int unsigned FRAC_W  = FRAC_BITS_DEF;
  localparam int unsigned COORD_W = FRAC_W + 2;
  localparam int          RANDOM_DIRS = 850;
  localparam int          CYCLE_LIMIT = 200000;

  localparam logic [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};
  localparam logic [COMP_W-1:0] COMP_ONE = COMP_W'(1);
  localparam logic [COMP_W-1:0] COMP_M1  = {COMP_W{1'b1}};

  typedef struct packed {
    logic [COMP_W-1:0] x;
    logic [COMP_W-1:0] y;
    logic [COMP_W-1:0] z;
  } dir_vec_t;

  typedef struct packed {
    face_t              face;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
  } face_uv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [COMP_W-1:0] dir_x = '0;
  logic [COMP_W-1:0] dir_y = '0;
  logic [COMP_W-1:0] dir_z = '0;
  logic busy;
  logic done;
  logic [2:0] face;
  logic [COORD_W-1:0] u_coord;
  logic [COORD_W-1:0] v_coord;

  dir_vec_t pending_dirs[$];
  face_uv_t expected_uvs[$];
  int errors = 0;
  int cycle_count = 0;
  int idle_left = 0;
  int burst_left = 1;

  sphere_dir_to_cube_face_uv_top #(
    .COMP_BITS(COMP_W),
    .FRAC_BITS(FRAC_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .dir_x(dir_x),
    .dir_y(dir_y),
    .dir_z(dir_z),
    .done(done),
    .face(face),
    .u_coord(u_coord),
    .v_coord(v_coord)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Magnitude of a two's complement component; the most negative value is exact
  function automatic longint unsigned comp_magnitude(input logic [COMP_W-1:0] c);
    longint unsigned m;
    m = 64'(c);
    if (c[COMP_W-1]) m = (64'd1 << COMP_W) - m;
    return m;
  endfunction

  // sign * trunc(minor * 2^FRAC / major), magnitude capped at 1.0
  function automatic logic [COORD_W-1:0] scaled_coord(input bit neg,
      input longint unsigned minor, input longint unsigned major);
    longint unsigned q;
    if (major == 0) return '0;
    q = (minor << FRAC_W) / major;
    if (q > (64'd1 << FRAC_W)) q = 64'd1 << FRAC_W;
    if (neg) q = -q;
    return q[COORD_W-1:0];
  endfunction

  // Face choice and per-face projection; X wins ties over Y, Y over Z
  function automatic face_uv_t project_to_face(input dir_vec_t d);
    face_uv_t r;
    longint unsigned ax, ay, az, major, um, vm;
    bit nx, ny, nz, un, vn;
    nx = d.x[COMP_W-1];
    ny = d.y[COMP_W-1];
    nz = d.z[COMP_W-1];
    ax = comp_magnitude(d.x);
    ay = comp_magnitude(d.y);
    az = comp_magnitude(d.z);
    if (ax >= ay && ax >= az) begin
      major  = ax;
      r.face = nx ? FACE_NEG_X : FACE_POS_X;
      um = az;
      un = nx ? nz : !nz;
      vm = ay;
      vn = ny;
    end else if (ay >= az) begin
      major  = ay;
      r.face = ny ? FACE_NEG_Y : FACE_POS_Y;
      um = ax;
      un = nx;
      vm = az;
      vn = ny ? !nz : nz;
    end else begin
      major  = az;
      r.face = nz ? FACE_NEG_Z : FACE_POS_Z;
      um = ax;
      un = nz ? !nx : nx;
      vm = ay;
      vn = ny;
    end
    r.u = scaled_coord(un, um, major);
    r.v = scaled_coord(vn, vm, major);
    return r;
  endfunction

  function automatic logic [COMP_W-1:0] with_rand_sign(input logic [COMP_W-1:0] m);
    return $urandom_range(0, 1) ? (~m + 1'b1) : m;
  endfunction

  function automatic logic [COMP_W-1:0] edge_comp();
    case ($urandom_range(0, 5))
      0: return COMP_MAX;
      1: return COMP_MIN;
      2: return '0;
      3: return COMP_ONE;
      4: return COMP_M1;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  task automatic queue_dir(input logic [COMP_W-1:0] x, y, z);
    dir_vec_t d;
    d.x = x;
    d.y = y;
    d.z = z;
    pending_dirs.push_back(d);
  endtask

  // Stimulus and end of run
  initial begin
    logic [COMP_W-1:0] m, lo, a, b, c;
    int sh;

    // directed: zero vector, axis extremes, ties, exact +-1.0, zero quotients
    queue_dir('0, '0, '0);
    queue_dir(COMP_MAX, '0, '0);
    queue_dir(COMP_MIN, '0, '0);
    queue_dir('0, COMP_MAX, '0);
    queue_dir('0, COMP_MIN, '0);
    queue_dir('0, '0, COMP_MAX);
    queue_dir('0, '0, COMP_MIN);
    queue_dir(24'd5, 24'd5, 24'd5);
    queue_dir(-24'sd5, 24'd5, -24'sd5);
    queue_dir('0, 24'd7, 24'd7);
    queue_dir('0, -24'sd7, 24'd7);
    queue_dir('0, 24'd3, -24'sd7);
    queue_dir(24'd2, -24'sd3, -24'sd9);
    queue_dir(COMP_MIN, COMP_MIN, COMP_MIN);
    queue_dir(COMP_MAX, COMP_MIN, COMP_MAX);
    queue_dir(COMP_MIN, COMP_MAX, COMP_MAX);
    queue_dir(COMP_MAX, COMP_M1, COMP_M1);
    queue_dir(COMP_ONE, COMP_M1, '0);
    queue_dir(COMP_M1, COMP_ONE, COMP_M1);
    queue_dir(24'd1000, 24'd999, -24'sd1);
    queue_dir(24'd3, -24'sd4, 24'd4);
    queue_dir(-24'sd3, 24'd5, COMP_M1);
    queue_dir(24'h123456, -24'sh234567, 24'h345678);
    queue_dir(-24'sh0ABCDE, 24'h0000FF, -24'sh7FFF00);

    // random: full range, small values, forced ties, edge values, common scales
    repeat (RANDOM_DIRS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          a = COMP_W'($urandom);
          b = COMP_W'($urandom);
          c = COMP_W'($urandom);
        end
        2: begin
          a = COMP_W'($urandom_range(0, 600) - 300);
          b = COMP_W'($urandom_range(0, 600) - 300);
          c = COMP_W'($urandom_range(0, 600) - 300);
        end
        3, 4: begin
          m  = COMP_W'($urandom_range(0, COMP_MAX));
          lo = COMP_W'($urandom_range(0, m));
          case ($urandom_range(0, 3))
            0: begin a = with_rand_sign(m);  b = with_rand_sign(m);  c = with_rand_sign(m);  end
            1: begin a = with_rand_sign(m);  b = with_rand_sign(m);  c = with_rand_sign(lo); end
            2: begin a = with_rand_sign(m);  b = with_rand_sign(lo); c = with_rand_sign(m);  end
            default: begin
              a = with_rand_sign(lo);
              b = with_rand_sign(m);
              c = with_rand_sign(m);
            end
          endcase
        end
        5: begin
          a = edge_comp();
          b = edge_comp();
          c = edge_comp();
        end
        default: begin
          // one scale per vector, as a real direction stream would have
          sh = $urandom_range(0, COMP_W - 1);
          a = $signed(COMP_W'($urandom)) >>> sh;
          b = $signed(COMP_W'($urandom)) >>> sh;
          c = $signed(COMP_W'($urandom)) >>> sh;
        end
      endcase
      queue_dir(a, b, c);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_dirs.size() != 0 || start || expected_uvs.size() != 0)
      @(posedge clk);
    repeat (FRAC_W + 10) @(posedge clk);

    if (errors == 0 && expected_uvs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Driver: bursts of back-to-back transactions separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_uvs.push_back(project_to_face({dir_x, dir_y, dir_z}));
        void'(pending_dirs.pop_front());
      end
      if (start && busy) begin
        // not taken yet: hold the transaction
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_dirs.size() != 0) begin
        start <= 1'b1;
        dir_x <= pending_dirs[0].x;
        dir_y <= pending_dirs[0].y;
        dir_z <= pending_dirs[0].z;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 8);
          idle_left  = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobed result against the oldest expectation
  always @(posedge clk) begin
    face_uv_t want;
    if (!rst && done) begin
      if (expected_uvs.size() == 0) begin
        $error("result with none expected: face %0d u %0d v %0d",
               face, $signed(u_coord), $signed(v_coord));
        errors++;
      end else begin
        want = expected_uvs.pop_front();
        if (face !== want.face) begin
          $error("face: expected %0d, got %0d", want.face, face);
          errors++;
        end
        if (u_coord !== want.u) begin
          $error("u_coord: expected %0d, got %0d", $signed(want.u), $signed(u_coord));
          errors++;
        end
        if (v_coord !== want.v) begin
          $error("v_coord: expected %0d, got %0d", $signed(want.v), $signed(v_coord));
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/sdcf_pkg.sv
sv/sdcf_select.sv
sv/sdcf_div_stage.sv
sv/sphere_dir_to_cube_face_uv_top.sv
bench/tb_sphere_dir_to_cube_face_uv_top.sv
